FILE: rtl/core/cellular_automaton_row_step_defines.svh
// assertion macros shared by the cellular automaton row step rtl
`ifndef CELLULAR_AUTOMATON_ROW_STEP_DEFINES_SVH
`define CELLULAR_AUTOMATON_ROW_STEP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked while out of reset
`define CAROW_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("carow assertion failed");
// checked on every edge, reset included
`define CAROW_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("carow assertion failed");
`else
`define CAROW_ASSERT(label, clk, rst, prop)
`define CAROW_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: rtl/core/carow_pkg.sv
package carow_pkg;

   // fixed field widths
   localparam int NUM_STATES_W = 4;
   localparam int WINDOW_LEN_W = 4;
   localparam int ROW_WIDTH_W  = 10;
   localparam int CSR_DATA_W   = 10;
   localparam int CSR_INDEX_W  = 2;
   localparam int RULE_INDEX_W = 10;
   localparam int CELL_W       = 3;
   localparam int COLUMN_W     = 9;

   // default sizes
   localparam int DEF_RULE_DEPTH = 1024;
   localparam int DEF_MAX_WINDOW = 9;
   localparam int DEF_MAX_COLS   = 512;

   // register reset values
   localparam logic [NUM_STATES_W-1:0] RST_NUM_STATES = 4'd2;
   localparam logic [WINDOW_LEN_W-1:0] RST_WINDOW_LEN = 4'd3;
   localparam logic [ROW_WIDTH_W-1:0]  RST_ROW_WIDTH  = 10'd64;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_STATES = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LEN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_WIDTH  = 2'd2;

   // request actions
   localparam logic ACT_RULE = 1'b0;
   localparam logic ACT_CELL = 1'b1;

   typedef struct packed {
      logic                    action;
      logic [RULE_INDEX_W-1:0] rule_index;
      logic [CELL_W-1:0]       cell_value;
   } req_type;

   typedef struct packed {
      logic [COLUMN_W-1:0] column;
      logic [CELL_W-1:0]   next_value;
      logic                last_of_run;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIGIT,
      ST_READ,
      ST_RESULT
   } state_type;

   // mid: window closes on the cell just received
   // right / left: wrapped columns at the two row ends
   typedef enum logic [1:0] {
      JOB_MID,
      JOB_RIGHT,
      JOB_LEFT
   } job_type;

   typedef struct packed {
      logic start;
      logic step;
   } acc_ctrl_type;

   typedef struct packed {
      logic              push;
      logic [CELL_W-1:0] value;
   } cell_push_type;

endpackage

FILE: rtl/core/carow_rule_mem.sv
module carow_rule_mem
   import carow_pkg::*;
#(
   parameter int RULE_DEPTH = DEF_RULE_DEPTH
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [RULE_INDEX_W-1:0]       wr_index,
   input  logic [CELL_W-1:0]             wr_value,
   input  logic                          rd_en,
   input  logic [$clog2(RULE_DEPTH)-1:0] rd_addr,
   output logic [CELL_W-1:0]             rd_value
);

   localparam int IDX_W = $clog2(RULE_DEPTH);
   localparam int RAW_SPAN = 1 << RULE_INDEX_W;
   // compare-subtract steps to bring a raw index below the depth
   localparam int WR_STEPS = (RULE_DEPTH >= RAW_SPAN) ? 0 :
                             $clog2((RAW_SPAN + RULE_DEPTH - 1) / RULE_DEPTH);

   logic [CELL_W-1:0] rule_ram_ff [RULE_DEPTH];
   logic [CELL_W-1:0] rd_value_ff;

   function automatic logic [IDX_W-1:0] fold_index(input logic [RULE_INDEX_W-1:0] raw);
      logic [RULE_INDEX_W:0] v;
      v = {1'b0, raw};
      for (int j = WR_STEPS - 1; j >= 0; j--) begin
         if (32'(v) >= (RULE_DEPTH << j)) begin
            v = v - (RULE_INDEX_W + 1)'(RULE_DEPTH << j);
         end
      end
      return IDX_W'(v);
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rule_ram_ff[fold_index(wr_index)] <= wr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_value_ff <= rule_ram_ff[rd_addr];
      end
   end

   assign rd_value = rd_value_ff;

endmodule

FILE: rtl/core/carow_cell_store.sv
module carow_cell_store
   import carow_pkg::*;
#(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   parameter int MAX_COLS   = DEF_MAX_COLS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cell_push_type               push,
   input  logic [$clog2(MAX_COLS)-1:0] head_col,
   input  logic [$clog2(MAX_COLS)-1:0] ref_col,
   input  logic [$clog2(MAX_COLS)-1:0] pos,
   output logic [CELL_W-1:0]           digit
);

   localparam int COL_W = $clog2(MAX_COLS);
   localparam int SEL_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   // newest cell first
   logic [CELL_W-1:0] window_ff [MAX_WINDOW];
   logic [CELL_W-1:0] window_in [MAX_WINDOW];
   // first cells of the row
   logic [CELL_W-1:0] head_ff [MAX_WINDOW];
   logic [CELL_W-1:0] head_in [MAX_WINDOW];
   logic [COL_W-1:0]  back_off;

   always_comb begin
      window_in = window_ff;
      head_in   = head_ff;
      if (push.push) begin
         for (int i = MAX_WINDOW - 1; i > 0; i--) begin
            window_in[i] = window_ff[i-1];
         end
         window_in[0] = push.value;
         if (32'(head_col) < MAX_WINDOW) begin
            head_in[SEL_W'(head_col)] = push.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '{default: '0};
         head_ff   <= '{default: '0};
      end else begin
         window_ff <= window_in;
         head_ff   <= head_in;
      end
   end

   // recent cells by distance from the reference column, else the row head
   always_comb begin
      back_off = ref_col - pos;
      if (32'(back_off) < MAX_WINDOW) begin
         digit = window_ff[SEL_W'(back_off)];
      end else if (32'(pos) < MAX_WINDOW) begin
         digit = head_ff[SEL_W'(pos)];
      end else begin
         digit = '0;
      end
   end

endmodule

FILE: rtl/core/carow_index_unit.sv
module carow_index_unit
   import carow_pkg::*;
#(
   parameter int RULE_DEPTH = DEF_RULE_DEPTH,
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   parameter int MAX_COLS   = DEF_MAX_COLS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  acc_ctrl_type                    ctrl,
   input  logic [$clog2(MAX_COLS)-1:0]     col,
   input  logic [$clog2(MAX_COLS+1)-1:0]   width,
   input  logic [$clog2(MAX_WINDOW+1)-1:0] half,
   input  logic [NUM_STATES_W-1:0]         num_states,
   input  logic [CELL_W-1:0]               digit,
   output logic [$clog2(MAX_COLS)-1:0]     pos,
   output logic [$clog2(MAX_WINDOW+1)-1:0] k,
   output logic [$clog2(RULE_DEPTH)-1:0]   idx
);

   localparam int COL_W = $clog2(MAX_COLS);
   localparam int WID_W = $clog2(MAX_COLS + 1);
   localparam int LEN_W = $clog2(MAX_WINDOW + 1);
   localparam int IDX_W = $clog2(RULE_DEPTH);
   localparam int SUM_W = IDX_W + 4;
   localparam int HMAX  = MAX_WINDOW / 2;
   localparam int P_W   = WID_W + 2;

   logic [COL_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] pw_ff, pw_in;
   logic [SUM_W-1:0] term;
   logic [SUM_W-1:0] scaled;
   logic [P_W-1:0]   start_p;
   logic [COL_W-1:0] pos_step;

   // operand below sixteen times the depth
   function automatic logic [IDX_W-1:0] reduce(input logic [SUM_W-1:0] v);
      logic [SUM_W-1:0] r;
      r = v;
      for (int j = 3; j >= 0; j--) begin
         if (r >= SUM_W'(RULE_DEPTH << j)) begin
            r = r - SUM_W'(RULE_DEPTH << j);
         end
      end
      return IDX_W'(r);
   endfunction

   always_comb begin
      // leftmost neighbour column, wrapped into the ring
      start_p = P_W'(col) - P_W'(half);
      for (int j = 0; j < HMAX; j++) begin
         if (start_p[P_W-1]) begin
            start_p = start_p + P_W'(width);
         end
      end
      pos_step = (WID_W'(pos_ff) + WID_W'(1) == width) ? '0 : pos_ff + COL_W'(1);
      term     = SUM_W'(idx_ff) + SUM_W'(pw_ff) * SUM_W'(digit);
      scaled   = SUM_W'(pw_ff) * SUM_W'(num_states);
   end

   always_comb begin
      pos_in = pos_ff;
      k_in   = k_ff;
      idx_in = idx_ff;
      pw_in  = pw_ff;
      if (ctrl.start) begin
         pos_in = COL_W'(start_p);
         k_in   = '0;
         idx_in = '0;
         pw_in  = IDX_W'(1);
      end else if (ctrl.step) begin
         pos_in = pos_step;
         k_in   = k_ff + LEN_W'(1);
         idx_in = reduce(term);
         pw_in  = reduce(scaled);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         k_ff   <= '0;
      end else begin
         pos_ff <= pos_in;
         k_ff   <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pw_ff  <= pw_in;
   end

   assign pos = pos_ff;
   assign k   = k_ff;
   assign idx = idx_ff;

endmodule

FILE: rtl/core/cellular_automaton_row_step.sv
// One generation step of a one-dimensional cellular automaton with num_states states on a
// ring of row_width cells. Load the rule table first with action 0 requests (one per cycle
// while idle, index folded into the table depth), then send the previous generation's cells
// with action 1 requests, column 0 first. Each new cell is the rule entry indexed by the
// window_len neighbours read as base-num_states digits, leftmost neighbour least
// significant, window starting window_len/2 columns to the left. A column whose window does
// not wrap is returned as soon as its rightmost neighbour arrives; the wrapped columns
// come out after the row's last cell, right end first, then left end, and last_of_run
// marks the final response of each request. Each response passes through a setup step, a
// digit step for each neighbour through the shared multiply-and-fold index unit, a rule
// table read and a load of the output register, which waits while a held response is
// stalled. A cell request that yields no response leaves the block idle. A finished
// response waits in the output register while the next one is computed. Registers may be
// written only while no request is in progress.
`include "cellular_automaton_row_step_defines.svh"

module cellular_automaton_row_step
   import carow_pkg::*;
#(
   parameter int RULE_DEPTH = DEF_RULE_DEPTH,
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   parameter int MAX_COLS   = DEF_MAX_COLS
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   // register writes
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int COL_W = $clog2(MAX_COLS);
   localparam int WID_W = $clog2(MAX_COLS + 1);
   localparam int LEN_W = $clog2(MAX_WINDOW + 1);
   localparam int IDX_W = $clog2(RULE_DEPTH);

   // configuration registers
   logic [NUM_STATES_W-1:0] num_states_ff, num_states_in;
   logic [WINDOW_LEN_W-1:0] window_len_ff, window_len_in;
   logic [ROW_WIDTH_W-1:0]  row_width_ff, row_width_in;

   // sequencer and job registers
   state_type        state_ff, state_in;
   job_type          kind_ff, kind_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] ref_ff, ref_in;
   logic             row_end_ff, row_end_in;
   logic [COL_W-1:0] count_ff, count_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   rsp_type          rsp_next;

   // effective geometry
   logic [WID_W-1:0] w_eff;
   logic [LEN_W-1:0] len_eff;
   logic [LEN_W-1:0] half;
   logic [LEN_W-1:0] right;
   logic [WID_W-1:0] lo;
   logic [WID_W-1:0] hi;

   // request decode
   logic             req_accept;
   logic             cell_accept;
   logic             rule_accept;
   logic [COL_W-1:0] cur_i;
   logic             row_end_now;
   logic             mid_now;
   logic [COL_W-1:0] mid_col;

   // following job
   job_type          sel_kind;
   logic [COL_W-1:0] sel_col;
   logic             sel_row_end;
   logic [WID_W-1:0] c_plus;
   logic             after_has;
   job_type          after_kind;
   logic [COL_W-1:0] after_col;

   // datapath links
   acc_ctrl_type     acc_ctrl;
   cell_push_type    cell_push;
   logic [COL_W-1:0] digit_pos;
   logic [LEN_W-1:0] digit_k;
   logic [IDX_W-1:0] rule_addr;
   logic [CELL_W-1:0] digit;
   logic             digit_last;
   logic             mem_we;
   logic             mem_re;
   logic [CELL_W-1:0] rule_value;
   logic             rsp_free;
   logic             rsp_load;

   // ---------------------------------------------------------------------------------------
   // configuration
   // ---------------------------------------------------------------------------------------
   always_comb begin
      num_states_in = num_states_ff;
      window_len_in = window_len_ff;
      row_width_in  = row_width_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_STATES: num_states_in = NUM_STATES_W'(csr_wdata);
            CSR_WINDOW_LEN: window_len_in = WINDOW_LEN_W'(csr_wdata);
            CSR_ROW_WIDTH:  row_width_in  = ROW_WIDTH_W'(csr_wdata);
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_states_ff <= RST_NUM_STATES;
         window_len_ff <= RST_WINDOW_LEN;
         row_width_ff  <= RST_ROW_WIDTH;
      end else begin
         num_states_ff <= num_states_in;
         window_len_ff <= window_len_in;
         row_width_ff  <= row_width_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // effective geometry: zero acts as one, oversize saturates
   // ---------------------------------------------------------------------------------------
   always_comb begin
      if (row_width_ff == '0) begin
         w_eff = WID_W'(1);
      end else if (32'(row_width_ff) > MAX_COLS) begin
         w_eff = WID_W'(MAX_COLS);
      end else begin
         w_eff = WID_W'(row_width_ff);
      end

      if (window_len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (32'(window_len_ff) > MAX_WINDOW) begin
         len_eff = LEN_W'(MAX_WINDOW);
      end else begin
         len_eff = LEN_W'(window_len_ff);
      end

      half  = len_eff >> 1;
      right = len_eff - LEN_W'(1) - half;
      // first wrapped column at the right end, and count of wrapped columns at the left
      lo = (w_eff >= WID_W'(right)) ? w_eff - WID_W'(right) : '0;
      hi = (WID_W'(half) < lo) ? WID_W'(half) : lo;
   end

   // ---------------------------------------------------------------------------------------
   // request decode
   // ---------------------------------------------------------------------------------------
   assign req_accept  = req_valid && !req_stall;
   assign cell_accept = req_accept && (req_data.action == ACT_CELL);
   assign rule_accept = req_accept && (req_data.action == ACT_RULE);

   always_comb begin
      // a count beyond a lowered width counts as the row's last cell
      cur_i = (32'(count_ff) > 32'(w_eff) - 1) ? COL_W'(w_eff - WID_W'(1)) : count_ff;
      row_end_now = (32'(cur_i) == 32'(w_eff) - 1);
      mid_now     = (32'(cur_i) + 1 >= 32'(len_eff));
      mid_col     = cur_i - COL_W'(right);
   end

   // ---------------------------------------------------------------------------------------
   // job after the current one: mid column, right end ascending, left end ascending
   // ---------------------------------------------------------------------------------------
   always_comb begin
      sel_kind    = (state_ff == ST_IDLE) ? JOB_MID : kind_ff;
      sel_col     = col_ff;
      sel_row_end = (state_ff == ST_IDLE) ? row_end_now : row_end_ff;
      c_plus      = WID_W'(sel_col) + WID_W'(1);
      after_has   = 1'b0;
      after_kind  = JOB_MID;
      after_col   = '0;
      case (sel_kind)
         JOB_MID: begin
            if (sel_row_end && (lo < w_eff)) begin
               after_has  = 1'b1;
               after_kind = JOB_RIGHT;
               after_col  = COL_W'(lo);
            end else if (sel_row_end && (hi != '0)) begin
               after_has  = 1'b1;
               after_kind = JOB_LEFT;
            end
         end
         JOB_RIGHT: begin
            if (c_plus < w_eff) begin
               after_has  = 1'b1;
               after_kind = JOB_RIGHT;
               after_col  = COL_W'(c_plus);
            end else if (hi != '0) begin
               after_has  = 1'b1;
               after_kind = JOB_LEFT;
            end
         end
         JOB_LEFT: begin
            if (c_plus < hi) begin
               after_has  = 1'b1;
               after_kind = JOB_LEFT;
               after_col  = COL_W'(c_plus);
            end
         end
         default: begin
            after_has = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------------------------
   assign digit_last = (32'(digit_k) + 1 == 32'(len_eff));
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cell_accept && (mid_now || after_has)) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: state_in = ST_DIGIT;
         ST_DIGIT: begin
            if (digit_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_RESULT;
         ST_RESULT: begin
            if (rsp_free) begin
               state_in = after_has ? ST_SETUP : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall       = (state_ff != ST_IDLE);
      mem_we          = rule_accept;
      cell_push.push  = cell_accept;
      cell_push.value = req_data.cell_value;
      acc_ctrl.start  = (state_ff == ST_SETUP);
      acc_ctrl.step   = (state_ff == ST_DIGIT);
      mem_re          = (state_ff == ST_READ);
      rsp_load        = (state_ff == ST_RESULT) && rsp_free;
   end

   // job registers
   always_comb begin
      kind_in    = kind_ff;
      col_in     = col_ff;
      ref_in     = ref_ff;
      row_end_in = row_end_ff;
      count_in   = count_ff;
      if (cell_accept) begin
         row_end_in = row_end_now;
         ref_in     = cur_i;
         count_in   = row_end_now ? '0 : cur_i + COL_W'(1);
         if (mid_now) begin
            kind_in = JOB_MID;
            col_in  = mid_col;
         end else begin
            kind_in = after_kind;
            col_in  = after_col;
         end
      end else if (rsp_load && after_has) begin
         kind_in = after_kind;
         col_in  = after_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         row_end_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         row_end_ff <= row_end_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      col_ff  <= col_in;
      ref_ff  <= ref_in;
   end

   // ---------------------------------------------------------------------------------------
   // datapath
   // ---------------------------------------------------------------------------------------
   carow_cell_store #(
      .MAX_WINDOW (MAX_WINDOW),
      .MAX_COLS   (MAX_COLS)
   ) u_cell_store (
      .clock    (clock),
      .reset    (reset),
      .push     (cell_push),
      .head_col (cur_i),
      .ref_col  (ref_ff),
      .pos      (digit_pos),
      .digit    (digit)
   );

   carow_index_unit #(
      .RULE_DEPTH (RULE_DEPTH),
      .MAX_WINDOW (MAX_WINDOW),
      .MAX_COLS   (MAX_COLS)
   ) u_index_unit (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (acc_ctrl),
      .col        (col_ff),
      .width      (w_eff),
      .half       (half),
      .num_states (num_states_ff),
      .digit      (digit),
      .pos        (digit_pos),
      .k          (digit_k),
      .idx        (rule_addr)
   );

   // table writes happen only in idle and reads only mid-job, so they never meet
   carow_rule_mem #(
      .RULE_DEPTH (RULE_DEPTH)
   ) u_rule_mem (
      .clock    (clock),
      .wr_en    (mem_we),
      .wr_index (req_data.rule_index),
      .wr_value (req_data.cell_value),
      .rd_en    (mem_re),
      .rd_addr  (rule_addr),
      .rd_value (rule_value)
   );

   // ---------------------------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------------------------
   always_comb begin
      rsp_next.column      = COLUMN_W'(col_ff);
      rsp_next.next_value  = rule_value;
      rsp_next.last_of_run = !after_has;
      rsp_data_in  = rsp_load ? rsp_next : rsp_data_ff;
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------------------------
   `CAROW_ASSERT(a_read_then_result, clock, reset, (state_ff == ST_READ) |=> (state_ff == ST_RESULT))
   `CAROW_ASSERT(a_digit_in_window, clock, reset, (state_ff == ST_DIGIT) |-> (32'(digit_k) < 32'(len_eff)))
   `CAROW_ASSERT(a_last_ends_run, clock, reset, (rsp_load && rsp_next.last_of_run) |=> (state_ff == ST_IDLE))
   `CAROW_ASSERT(a_no_rw_overlap, clock, reset, !(mem_we && mem_re))
   `CAROW_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (!rsp_valid && (state_ff == ST_IDLE)))

endmodule

FILE: tb/cellular_automaton_row_step_checker.sv
module cellular_automaton_row_step_checker
   import carow_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending
);

   localparam int unsigned DEPTH    = DEF_RULE_DEPTH;
   localparam int unsigned MAX_WIN  = DEF_MAX_WINDOW;
   localparam int unsigned MAX_COLS = DEF_MAX_COLS;

   logic [CELL_W-1:0]       rule_mem [DEPTH];
   logic [CELL_W-1:0]       recent_cells [MAX_WIN];
   logic [CELL_W-1:0]       head_cells [MAX_WIN];
   int unsigned             col_count;
   logic [NUM_STATES_W-1:0] cfg_states;
   logic [WINDOW_LEN_W-1:0] cfg_window;
   logic [ROW_WIDTH_W-1:0]  cfg_width;

   rsp_type next_gen_q [$];
   rsp_type held;
   logic    have_held;
   int      mismatches;

   initial begin
      fail_count = 0;
      pending    = 0;
      have_held  = 1'b0;
      mismatches = 0;
   end

   // new state of a column whose window wraps around the ring
   function automatic logic [CELL_W-1:0] wrap_value(input int unsigned col,
                                                    input int unsigned wd,
                                                    input int unsigned lw);
      int unsigned half, idx, pw, k, pos, d, nbr;
      half = lw / 2;
      idx  = 0;
      pw   = 1;
      for (k = 0; k < lw; k++) begin
         pos = (col + k + wd * MAX_WIN - half) % wd;
         d   = wd - 1 - pos;
         if (d < MAX_WIN) nbr = recent_cells[d];
         else if (pos < MAX_WIN) nbr = head_cells[pos];
         else nbr = 0;
         idx = (idx + pw * nbr) % DEPTH;
         pw  = (pw * cfg_states) % DEPTH;
      end
      return rule_mem[idx];
   endfunction

   // the newest result is held back until we know whether it ends the request
   task automatic add_result(input int unsigned col, input logic [CELL_W-1:0] val);
      if (have_held) next_gen_q.push_back(held);
      held.column      = COLUMN_W'(col);
      held.next_value  = val;
      held.last_of_run = 1'b0;
      have_held        = 1'b1;
   endtask

   always @(posedge clock) begin
      rsp_type     want;
      int unsigned wd, lw, half, tail, at, lo, hi, idx, pw, c;
      int          k;
      if (reset) begin
         for (k = 0; k < MAX_WIN; k++) begin
            recent_cells[k] = '0;
            head_cells[k]   = '0;
         end
         col_count  = 0;
         cfg_states = RST_NUM_STATES;
         cfg_window = RST_WINDOW_LEN;
         cfg_width  = RST_ROW_WIDTH;
         have_held  = 1'b0;
         next_gen_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_NUM_STATES: cfg_states = csr_wdata[NUM_STATES_W-1:0];
               CSR_WINDOW_LEN: cfg_window = csr_wdata[WINDOW_LEN_W-1:0];
               CSR_ROW_WIDTH:  cfg_width  = csr_wdata[ROW_WIDTH_W-1:0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            if (req_data.action == ACT_RULE) begin
               rule_mem[req_data.rule_index % DEPTH] = req_data.cell_value;
            end else begin
               wd   = (cfg_width == 0) ? 1 : ((cfg_width > MAX_COLS) ? MAX_COLS : cfg_width);
               lw   = (cfg_window == 0) ? 1 : ((cfg_window > MAX_WIN) ? MAX_WIN : cfg_window);
               half = lw / 2;
               tail = lw - 1 - half;
               at   = (col_count > wd - 1) ? wd - 1 : col_count;
               if (at < MAX_WIN) head_cells[at] = req_data.cell_value;
               for (k = MAX_WIN - 1; k > 0; k--) recent_cells[k] = recent_cells[k - 1];
               recent_cells[0] = req_data.cell_value;
               // window closes on this cell without wrapping
               if (at >= tail && at - tail >= half) begin
                  idx = 0;
                  pw  = 1;
                  for (k = 0; k < lw; k++) begin
                     idx = (idx + pw * recent_cells[lw - 1 - k]) % DEPTH;
                     pw  = (pw * cfg_states) % DEPTH;
                  end
                  add_result(at - tail, rule_mem[idx]);
               end
               // row end: right-hand wrapped columns, then left-hand ones
               if (at == wd - 1) begin
                  lo = (wd >= tail) ? wd - tail : 0;
                  hi = (half < lo) ? half : lo;
                  for (c = lo; c < wd; c++) add_result(c, wrap_value(c, wd, lw));
                  for (c = 0; c < hi; c++) add_result(c, wrap_value(c, wd, lw));
                  col_count = 0;
               end else begin
                  col_count = at + 1;
               end
               if (have_held) begin
                  held.last_of_run = 1'b1;
                  next_gen_q.push_back(held);
                  have_held = 1'b0;
               end
            end
         end

         if (rsp_valid && !rsp_stall) begin
            if (next_gen_q.size() == 0) begin
               $error("column: nothing expected, got column %0d value %0d",
                      rsp_data.column, rsp_data.next_value);
               mismatches++;
            end else begin
               want = next_gen_q.pop_front();
               if (rsp_data.column !== want.column) begin
                  $error("column: expected %0d, got %0d", want.column, rsp_data.column);
                  mismatches++;
               end
               if (rsp_data.next_value !== want.next_value) begin
                  $error("next_value: expected %0d, got %0d",
                         want.next_value, rsp_data.next_value);
                  mismatches++;
               end
               if (rsp_data.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0d, got %0d",
                         want.last_of_run, rsp_data.last_of_run);
                  mismatches++;
               end
            end
         end
      end
      fail_count <= mismatches;
      pending    <= next_gen_q.size();
   end

endmodule

FILE: tb/tb_cellular_automaton_row_step.sv
module tb_cellular_automaton_row_step;
   import carow_pkg::*;

   // the low entries are loaded first; every setting keeps the rule index below this
   localparam int unsigned RULE_SPAN    = 64;
   localparam int unsigned BIG_ROW      = DEF_MAX_COLS;
   localparam int unsigned RANDOM_ITEMS = 26;
   // longer than the longest row end, so this covers any tail of work
   localparam int unsigned DRAIN_CYCLES = 150;
   localparam int unsigned CYCLE_LIMIT  = 400000;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_NUM_STATES;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   // high while neither side may idle
   logic                   no_idle   = 1'b0;
   int                     fail_count;
   int                     pending;
   int unsigned            cycles    = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   cellular_automaton_row_step i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cellular_automaton_row_step_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // receiver back-pressure, about one cycle in three while idling is allowed
   always @(posedge clock) rsp_stall <= !no_idle && ($urandom_range(99, 0) < 35);

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_cellular_automaton_row_step NOT OK");
         $finish;
      end
   end

   // sum of the digit weights of one rule index, capped once it leaves the loaded span
   function automatic int unsigned index_weight(input int unsigned states,
                                                input int unsigned window);
      int unsigned lw, pw, wsum, k;
      lw   = (window == 0) ? 1 : ((window > DEF_MAX_WINDOW) ? DEF_MAX_WINDOW : window);
      pw   = 1;
      wsum = 0;
      for (k = 0; k < lw; k++) begin
         wsum = wsum + pw;
         pw   = (pw * states > RULE_SPAN) ? RULE_SPAN : pw * states;
      end
      return wsum;
   endfunction

   // one request: random idle cycles first, then hold until taken
   task automatic send_request(input logic act, input logic [RULE_INDEX_W-1:0] idx,
                               input logic [CELL_W-1:0] val);
      req_type r;
      while (!no_idle && $urandom_range(99, 0) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      r.action     = act;
      r.rule_index = idx;
      r.cell_value = val;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   // cell requests carry a junk rule index, which the block must ignore
   task automatic send_cell(input logic [CELL_W-1:0] val);
      send_request(ACT_CELL, RULE_INDEX_W'($urandom), val);
   endtask

   // wait for every outstanding cell, then for the block to go quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // registers change only with the block idle
   task automatic configure(input int unsigned states, input int unsigned window,
                            input int unsigned width);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_NUM_STATES;
      csr_wdata <= CSR_DATA_W'(states);
      @(posedge clock);
      csr_index <= CSR_WINDOW_LEN;
      csr_wdata <= CSR_DATA_W'(window);
      @(posedge clock);
      csr_index <= CSR_ROW_WIDTH;
      csr_wdata <= CSR_DATA_W'(width);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int unsigned k, n, sent, states, window, width, pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // the low entries get values before any cell can look one up
      for (k = 0; k < RULE_SPAN; k++)
         send_request(ACT_RULE, RULE_INDEX_W'(k), CELL_W'($urandom_range(7, 0)));

      // reset settings: base 2, window of three, 64 columns
      send_cell(3'd7);
      send_cell(3'd0);
      send_cell(3'd7);
      // rewrite the entries at both ends of the table
      send_request(ACT_RULE, 10'd1023, 3'd7);
      send_request(ACT_RULE, 10'd0, 3'd0);

      // widest base; the row begun above now wraps at column 8
      configure(8, 2, 9);
      send_cell(3'd7);
      send_cell(3'd7);
      send_cell(3'd0);
      send_cell(3'd7);
      send_cell(3'd0);
      send_cell(3'd0);

      // window above the limit on a ring narrower than the window
      configure(1, 15, 3);
      send_cell(3'd1);
      send_cell(3'd6);
      send_cell(3'd7);

      // base zero, then the ring shrinks below the cells already in
      configure(0, 4, 9);
      send_cell(3'd5);
      send_cell(3'd2);
      send_cell(3'd7);
      send_cell(3'd0);
      configure(2, 0, 2);
      send_cell(3'd3);

      // zero width acts as one column, so every cell closes a row
      configure(1, 1, 0);
      send_cell(3'd4);
      send_cell(3'd7);

      // random phases, mostly sane settings on short rings
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         do begin
            pick   = $urandom_range(9, 0);
            states = (pick < 7) ? $urandom_range(8, 2) : $urandom_range(15, 0);
            pick   = $urandom_range(9, 0);
            window = (pick < 7) ? $urandom_range(9, 1) : $urandom_range(15, 0);
         end while (7 * index_weight(states, window) >= RULE_SPAN);
         pick = $urandom_range(19, 0);
         if (sent == 0) width = $urandom_range(12, 9);
         else if (pick < 15) width = $urandom_range(24, 9);
         else if (pick < 17) width = $urandom_range(8, 0);
         else width = $urandom_range(1023, 512);
         // the first phase runs flat out, later ones only now and then
         no_idle <= (sent == 0) || ($urandom_range(9, 0) == 0);
         configure(states, window, width);
         // wide rings stay partial; a later narrow ring ends them early
         if (sent == 0) n = 16;
         else n = (width >= BIG_ROW) ? $urandom_range(20, 1)
                                     : $urandom_range(width + width / 2 + 2, 2);
         if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
         for (k = 0; k < n; k++) begin
            if ($urandom_range(9, 0) == 0)
               send_request(ACT_RULE, RULE_INDEX_W'($urandom),
                            CELL_W'($urandom_range(7, 0)));
            else
               send_cell(CELL_W'($urandom_range(7, 0)));
            sent++;
         end
      end

      settle();
      if (fail_count == 0 && pending == 0) begin
         $display("tb_cellular_automaton_row_step OK");
      end else begin
         $display("tb_cellular_automaton_row_step NOT OK");
      end
      $finish;
   end

endmodule
